// ----- rtl/jsu_pkg.sv -----
// Shared types, codes and helper functions of the JSON string unescaper.
package jsu_pkg;

  // Decoder phase
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_STR  = 2'd1,
    PH_ESC  = 2'd2,
    PH_HEX  = 2'd3
  } phase_e;

  // Result event codes
  localparam logic [1:0] EV_DATA   = 2'd0;
  localparam logic [1:0] EV_CLOSE  = 2'd1;
  localparam logic [1:0] EV_NOOPEN = 2'd2;
  localparam logic [1:0] EV_END    = 2'd3;

  // Characters the decoder reacts to
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_U      = 8'h75;

  // UTF-8 encoding constants
  localparam logic [7:0]  UTF8_LEAD2    = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3    = 8'hE0;
  localparam logic [7:0]  UTF8_CONT     = 8'h80;
  localparam logic [15:0] CP_ONE_LIMIT  = 16'h0080;
  localparam logic [15:0] CP_TWO_LIMIT  = 16'h0800;

  // Output byte limit after reset (capacity 64 minus one)
  localparam logic [7:0] LIMIT_RESET = 8'd63;

  // Encoded code point
  typedef struct packed {
    logic [1:0]      len;
    logic [2:0][7:0] bytes;
  } jsu_utf8_t;

  // All results caused by one input character
  typedef struct packed {
    logic [1:0]      nbytes;     // data bytes, 0..3
    logic [2:0][7:0] bytes;      // bytes[0] goes out first
    logic [7:0]      base;       // written count before the first byte
    logic            has_tail;   // an end, close or error event follows
    logic [1:0]      tail_ev;
    logic [7:0]      tail_wr;
    logic            tail_trunc;
  } jsu_group_t;

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
    return v;
  endfunction

  function automatic jsu_utf8_t utf8_encode(input logic [15:0] cp);
    jsu_utf8_t r;
    r = '0;
    if (cp < CP_ONE_LIMIT) begin
      r.len      = 2'd1;
      r.bytes[0] = cp[7:0];
    end else if (cp < CP_TWO_LIMIT) begin
      r.len      = 2'd2;
      r.bytes[0] = UTF8_LEAD2 | {3'b000, cp[10:6]};
      r.bytes[1] = UTF8_CONT | {2'b00, cp[5:0]};
    end else begin
      r.len      = 2'd3;
      r.bytes[0] = UTF8_LEAD3 | {4'b0000, cp[15:12]};
      r.bytes[1] = UTF8_CONT | {2'b00, cp[11:6]};
      r.bytes[2] = UTF8_CONT | {2'b00, cp[5:0]};
    end
    return r;
  endfunction

endpackage

// ----- rtl/json_string_unescaper_top.sv -----
// The first result of a character passes through the result queue and the output register.
// Throughput: one character per cycle; a character that yields n results holds the
// output sequencer for n transfers, and the result queue absorbs the difference.
// A full result queue stalls the input.
// Reset: asynchronous, active low; decoder idle, queue empty, capacity 64.
module json_string_unescaper_top import jsu_pkg::*; #(
  parameter int QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [8:0] cfg_capacity_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] ch_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] event_res_o,
  output logic [7:0] value_o,
  output logic [7:0] written_o,
  output logic       truncated_o,
  output logic       last_o
);

  logic       q_full, q_valid, q_pop, grp_push, in_fire;
  jsu_group_t grp, q_head;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full;
  assign in_fire     = in_valid_i & ~q_full;

  jsu_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_capacity_i (cfg_capacity_i),
    .in_fire_i      (in_fire),
    .ch_i           (ch_i),
    .grp_push_o     (grp_push),
    .grp_o          (grp)
  );

  jsu_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (grp_push),
    .data_i  (grp),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_head)
  );

  jsu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_i       (q_head),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .event_res_o  (event_res_o),
    .value_o      (value_o),
    .written_o    (written_o),
    .truncated_o  (truncated_o),
    .last_o       (last_o)
  );

endmodule

// ----- rtl/jsu_front.sv -----
// Front end: character decoder that turns each character into at most one result group.
module jsu_front import jsu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic [8:0] cfg_capacity_i,
  input  logic       in_fire_i,
  input  logic [7:0] ch_i,
  output logic       grp_push_o,
  output jsu_group_t grp_o
);

  phase_e      phase_q, phase_d;
  logic [1:0]  hex_q, hex_d;
  logic [15:0] code_q, code_d;
  logic [7:0]  count_q;
  logic        dropped_q;
  logic [7:0]  limit_q, limit_d;

  logic        is_ws;
  logic [15:0] cp_next;
  jsu_utf8_t   enc_cur, enc_next;

  logic            put_en;
  logic [1:0]      put_k;
  logic [2:0][7:0] put_b;
  logic            fin_en;
  logic [1:0]      fin_ev;
  logic            err_en;
  logic            open_en;

  logic        fits;
  logic [7:0]  cnt_after;
  logic        drop_after;
  logic [8:0]  cap_m1;

  assign is_ws = (ch_i == CH_SPACE) || (ch_i == CH_LF) || (ch_i == CH_CR) || (ch_i == CH_TAB);
  assign cp_next  = {code_q[11:0], hex_nibble(ch_i)};
  assign enc_cur  = utf8_encode(code_q);
  assign enc_next = utf8_encode(cp_next);

  // Byte limit from capacity: capacity minus one, saturated to 8 bits; capacity zero gives zero
  assign cap_m1 = cfg_capacity_i - 9'd1;
  always_comb begin
    limit_d = limit_q;
    if (cfg_valid_i) begin
      if (cfg_capacity_i == 9'd0) limit_d = 8'd0;
      else if (cap_m1[8])        limit_d = 8'hFF;
      else                       limit_d = cap_m1[7:0];
    end
  end

  // Next phase
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PH_IDLE: if (ch_i == CH_QUOTE) phase_d = PH_STR;
      PH_STR: begin
        if (ch_i == CH_NUL || ch_i == CH_QUOTE) phase_d = PH_IDLE;
        else if (ch_i == CH_BSLASH)             phase_d = PH_ESC;
      end
      PH_ESC: begin
        if (ch_i == CH_NUL)    phase_d = PH_IDLE;
        else if (ch_i == CH_U) phase_d = PH_HEX;
        else                   phase_d = PH_STR;
      end
      PH_HEX: begin
        if (ch_i == CH_NUL)       phase_d = PH_IDLE;
        else if (hex_q == 2'd3)   phase_d = PH_STR;
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  // Classification: which bytes to emit, whether the string ends or opens, or a character is an error
  always_comb begin
    put_en  = 1'b0;
    put_k   = 2'd0;
    put_b   = '0;
    fin_en  = 1'b0;
    fin_ev  = EV_END;
    err_en  = 1'b0;
    open_en = 1'b0;
    hex_d   = hex_q;
    code_d  = code_q;
    case (phase_q)
      PH_IDLE: begin
        if (ch_i == CH_QUOTE) begin
          open_en = 1'b1;
          hex_d   = 2'd0;
          code_d  = '0;
        end else if (!is_ws) begin
          err_en = 1'b1;
        end
      end
      PH_STR: begin
        if (ch_i == CH_NUL) begin
          fin_en = 1'b1;
        end else if (ch_i == CH_QUOTE) begin
          fin_en = 1'b1;
          fin_ev = EV_CLOSE;
        end else if (ch_i != CH_BSLASH) begin
          put_en   = 1'b1;
          put_k    = 2'd1;
          put_b[0] = ch_i;
        end
      end
      PH_ESC: begin
        if (ch_i == CH_NUL) begin
          fin_en = 1'b1;
        end else if (ch_i == CH_U) begin
          hex_d  = 2'd0;
          code_d = '0;
        end else begin
          put_en = 1'b1;
          put_k  = 2'd1;
          case (ch_i)
            CH_N:    put_b[0] = CH_LF;
            CH_T:    put_b[0] = CH_TAB;
            CH_R:    put_b[0] = CH_CR;
            default: put_b[0] = ch_i;
          endcase
        end
      end
      PH_HEX: begin
        if (ch_i == CH_NUL) begin
          // partial code point goes out before the end event
          put_en = 1'b1;
          put_k  = enc_cur.len;
          put_b  = enc_cur.bytes;
          fin_en = 1'b1;
        end else if (hex_q == 2'd3) begin
          put_en = 1'b1;
          put_k  = enc_next.len;
          put_b  = enc_next.bytes;
          hex_d  = 2'd0;
          code_d = '0;
        end else begin
          code_d = cp_next;
          hex_d  = hex_q + 2'd1;
        end
      end
      default: ;
    endcase
    if (fin_en) begin
      hex_d  = 2'd0;
      code_d = '0;
    end
  end

  // Room check: a multibyte unit goes out whole or not at all
  assign fits       = ({1'b0, count_q} + {7'd0, put_k}) <= {1'b0, limit_q};
  assign cnt_after  = (put_en && fits) ? count_q + {6'd0, put_k} : count_q;
  assign drop_after = dropped_q | (put_en & ~fits);

  // Result group
  always_comb begin
    grp_o            = '0;
    grp_o.nbytes     = (put_en && fits) ? put_k : 2'd0;
    grp_o.bytes      = put_b;
    grp_o.base       = count_q;
    grp_o.has_tail   = fin_en | err_en;
    grp_o.tail_ev    = err_en ? EV_NOOPEN : fin_ev;
    grp_o.tail_wr    = err_en ? 8'd0 : cnt_after;
    grp_o.tail_trunc = err_en ? 1'b0 : drop_after;
  end

  assign grp_push_o = in_fire_i & ((grp_o.nbytes != 2'd0) | grp_o.has_tail);

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      hex_q     <= 2'd0;
      code_q    <= '0;
      count_q   <= '0;
      dropped_q <= 1'b0;
      limit_q   <= LIMIT_RESET;
    end else begin
      limit_q <= limit_d;
      if (in_fire_i) begin
        phase_q   <= phase_d;
        hex_q     <= hex_d;
        code_q    <= code_d;
        count_q   <= open_en ? 8'd0 : cnt_after;
        dropped_q <= open_en ? 1'b0 : drop_after;
      end
    end
  end

endmodule

// ----- rtl/jsu_fifo.sv -----
// Small queue of result groups between the decoder and the output sequencer.
module jsu_fifo import jsu_pkg::*; #(
  parameter int Depth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  jsu_group_t data_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output jsu_group_t data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  jsu_group_t          mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     cnt_q;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ----- rtl/jsu_back.sv -----
// Back end: walks each result group and drives one result per transfer.
module jsu_back import jsu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  jsu_group_t head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] event_res_o,
  output logic [7:0] value_o,
  output logic [7:0] written_o,
  output logic       truncated_o,
  output logic       last_o
);

  logic [1:0] idx_q;
  logic       out_valid_q;
  logic [1:0] ev_q;
  logic [7:0] val_q, wr_q;
  logic       trunc_q, last_q;

  logic       load;
  logic [2:0] total;
  logic       is_last;
  logic       is_byte;
  logic [7:0] sel_byte;

  // Output register is free when empty or being taken
  assign load    = head_valid_i & (~out_valid_q | ~out_stall_i);
  assign total   = {1'b0, head_i.nbytes} + {2'b00, head_i.has_tail};
  assign is_last = ({1'b0, idx_q} + 3'd1) == total;
  assign is_byte = idx_q < head_i.nbytes;
  assign pop_o   = load & is_last;

  always_comb begin
    case (idx_q)
      2'd0:    sel_byte = head_i.bytes[0];
      2'd1:    sel_byte = head_i.bytes[1];
      2'd2:    sel_byte = head_i.bytes[2];
      default: sel_byte = 8'd0;
    endcase
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      last_q <= is_last;
      if (is_byte) begin
        ev_q    <= EV_DATA;
        val_q   <= sel_byte;
        wr_q    <= head_i.base + {6'd0, idx_q} + 8'd1;
        trunc_q <= 1'b0;
      end else begin
        ev_q    <= head_i.tail_ev;
        val_q   <= 8'd0;
        wr_q    <= head_i.tail_wr;
        trunc_q <= head_i.tail_trunc;
      end
    end
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q       <= is_last ? 2'd0 : idx_q + 2'd1;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign event_res_o = ev_q;
  assign value_o     = val_q;
  assign written_o   = wr_q;
  assign truncated_o = trunc_q;
  assign last_o      = last_q;

endmodule

// ----- verif/tb_json_string_unescaper_top.sv -----
// Self-checking testbench for the streaming JSON string unescaper: directed table, then random strings.
module tb_json_string_unescaper_top;
  import jsu_pkg::*;

  localparam int HOLD_CYCLES   = 60;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 10;
  localparam int PHASE_CHARS   = 3;
  localparam int NUM_PHASES    = 10;

  // One result as it leaves the block
  typedef struct packed {
    logic [1:0] ev;
    logic [7:0] val;
    logic [7:0] wr;
    logic       trunc;
    logic       last;
  } res_t;

  // Directed row: a character, optionally with its single result typed in
  typedef struct packed {
    logic [7:0] ch;
    logic       typed;
    logic [1:0] ev;
    logic [7:0] wr;
    logic       trunc;
  } dir_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [8:0] cfg_capacity_i;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] ch_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [1:0] event_res_o;
  logic [7:0] value_o;
  logic [7:0] written_o;
  logic       truncated_o;
  logic       last_o;

  json_string_unescaper_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_capacity_i (cfg_capacity_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .ch_i           (ch_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .event_res_o    (event_res_o),
    .value_o        (value_o),
    .written_o      (written_o),
    .truncated_o    (truncated_o),
    .last_o         (last_o)
  );

  // Decoder mirror
  phase_e      ph;
  logic [1:0]  nhex;
  logic [15:0] cp;
  logic [7:0]  cnt;
  logic        drop;
  logic [8:0]  cap;

  res_t     unescaped_q[$];   // results still owed by the block
  res_t     char_results[$];  // results of the character being decoded
  dir_row_t dir_tab[25];
  int       fail_cnt;
  int       chars_sent;
  bit       quiet;
  int       hold_req;
  int       hold_seen;
  int       hold_left;

  always #5 clk_i = ~clk_i;

  // Byte budget of one string
  function automatic logic [7:0] byte_budget(input logic [8:0] c);
    if (c == 9'd0) return 8'd0;
    if (c > 9'd256) return 8'd255;
    return 8'(c - 9'd1);
  endfunction

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    case (c) inside
      ["0":"9"]:            return c[3:0];
      ["a":"f"], ["A":"F"]: return c[3:0] + 4'd9;
      default:              return 4'd0;
    endcase
  endfunction

  task automatic add_result(input logic [1:0] ev, input logic [7:0] val,
                            input logic [7:0] wr, input logic tr);
    char_results.push_back('{ev, val, wr, tr, 1'b0});
  endtask

  // A multibyte unit goes out whole or not at all
  task automatic emit_unit(input int k, input logic [7:0] b0, input logic [7:0] b1,
                           input logic [7:0] b2);
    logic [7:0] b[3];
    b = '{b0, b1, b2};
    if (int'(cnt) + k > int'(byte_budget(cap))) begin
      drop = 1'b1;
    end else begin
      for (int i = 0; i < k; i++) begin
        cnt = cnt + 8'd1;
        add_result(EV_DATA, b[i], cnt, 1'b0);
      end
    end
  endtask

  task automatic emit_code_point(input logic [15:0] v);
    if (v < CP_ONE_LIMIT) begin
      emit_unit(1, v[7:0], 8'h00, 8'h00);
    end else if (v < CP_TWO_LIMIT) begin
      emit_unit(2, UTF8_LEAD2 | 8'(v[10:6]), UTF8_CONT | 8'(v[5:0]), 8'h00);
    end else begin
      emit_unit(3, UTF8_LEAD3 | 8'(v[15:12]), UTF8_CONT | 8'(v[11:6]),
                UTF8_CONT | 8'(v[5:0]));
    end
  endtask

  task automatic close_string(input logic [1:0] ev);
    add_result(ev, 8'h00, cnt, drop);
    ph   = PH_IDLE;
    nhex = 2'd0;
    cp   = 16'h0000;
  endtask

  // Expected results of one character
  task automatic decode_char(input logic [7:0] c);
    char_results.delete();
    case (ph)
      PH_IDLE: begin
        if (c == CH_SPACE || c == CH_LF || c == CH_CR || c == CH_TAB) begin
          // whitespace between strings is skipped
        end else if (c == CH_QUOTE) begin
          ph   = PH_STR;
          cnt  = 8'd0;
          drop = 1'b0;
          nhex = 2'd0;
          cp   = 16'h0000;
        end else begin
          add_result(EV_NOOPEN, 8'h00, 8'h00, 1'b0);
        end
      end
      PH_STR: begin
        if (c == CH_NUL) close_string(EV_END);
        else if (c == CH_QUOTE) close_string(EV_CLOSE);
        else if (c == CH_BSLASH) ph = PH_ESC;
        else emit_unit(1, c, 8'h00, 8'h00);
      end
      PH_ESC: begin
        if (c == CH_NUL) begin
          close_string(EV_END);
        end else if (c == CH_U) begin
          ph   = PH_HEX;
          nhex = 2'd0;
          cp   = 16'h0000;
        end else begin
          ph = PH_STR;
          case (c)
            CH_N:    emit_unit(1, CH_LF, 8'h00, 8'h00);
            CH_T:    emit_unit(1, CH_TAB, 8'h00, 8'h00);
            CH_R:    emit_unit(1, CH_CR, 8'h00, 8'h00);
            default: emit_unit(1, c, 8'h00, 8'h00);
          endcase
        end
      end
      default: begin
        // end of text inside \u flushes the partial code point
        if (c == CH_NUL) begin
          emit_code_point(cp);
          close_string(EV_END);
        end else begin
          cp = {cp[11:0], nibble_of(c)};
          if (nhex == 2'd3) begin
            emit_code_point(cp);
            nhex = 2'd0;
            cp   = 16'h0000;
            ph   = PH_STR;
          end else begin
            nhex = nhex + 2'd1;
          end
        end
      end
    endcase
  endtask

  // Offer one character, wait for its transfer, then record what it should cause
  task automatic send_char(input logic [7:0] c, input bit typed = 1'b0,
                           input res_t typed_res = '0);
    while (!quiet && $urandom_range(0, 99) < 12) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    ch_i       <= c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    chars_sent++;
    decode_char(c);
    if (typed) begin
      unescaped_q.push_back(typed_res);
    end else if (char_results.size() != 0) begin
      char_results[char_results.size() - 1].last = 1'b1;
      foreach (char_results[i]) unescaped_q.push_back(char_results[i]);
    end
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'("0") + 8'(v);
    if ($urandom_range(0, 1) == 0) return 8'("a") + 8'(v) - 8'd10;
    return 8'("A") + 8'(v) - 8'd10;
  endfunction

  // One piece of string content: plain byte, escape, \u sequence or raw noise
  task automatic send_piece();
    logic [7:0]  c;
    logic [15:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        c = 8'($urandom_range(1, 255));
        if (c == CH_QUOTE || c == CH_BSLASH) c = c + 8'd1;
        send_char(c);
      end
      4, 5: begin
        send_char(CH_BSLASH);
        case ($urandom_range(0, 6))
          0:       c = CH_N;
          1:       c = CH_T;
          2:       c = CH_R;
          3:       c = CH_QUOTE;
          4:       c = CH_BSLASH;
          5:       c = "/";
          default: c = 8'($urandom_range(1, 255));
        endcase
        if (c == CH_U) c = CH_N;
        send_char(c);
      end
      6, 7, 8: begin
        case ($urandom_range(0, 2))
          0:       v = 16'($urandom_range(0, 16'h007F));
          1:       v = 16'($urandom_range(16'h0080, 16'h07FF));
          default: v = 16'($urandom_range(16'h0800, 16'hFFFF));
        endcase
        send_char(CH_BSLASH);
        send_char(CH_U);
        for (int i = 3; i >= 0; i--) begin
          // now and then a letter that is not a hex digit
          if ($urandom_range(0, 9) == 0) send_char(8'($urandom_range(8'h67, 8'h7A)));
          else send_char(hex_char(v[4*i +: 4]));
        end
      end
      default: send_char(8'($urandom_range(0, 255)));
    endcase
  endtask

  // Mostly well-formed strings; some noise and broken endings
  task automatic send_token(input int max_pieces);
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 3))
        0:       send_char(CH_SPACE);
        1:       send_char(CH_TAB);
        2:       send_char(CH_LF);
        default: send_char(CH_CR);
      endcase
    end
    if ($urandom_range(0, 99) < 15) begin
      send_char(8'($urandom_range(0, 255)));
    end else begin
      send_char(CH_QUOTE);
      repeat ($urandom_range(0, max_pieces)) send_piece();
      case ($urandom_range(0, 9))
        0: send_char(CH_NUL);
        1: begin
          send_char(CH_BSLASH);
          send_char(CH_NUL);
        end
        2: begin
          send_char(CH_BSLASH);
          send_char(CH_U);
          repeat ($urandom_range(0, 3)) send_char(hex_char(4'($urandom_range(0, 15))));
          send_char(CH_NUL);
        end
        default: send_char(CH_QUOTE);
      endcase
    end
  endtask

  // Register write once the block has drained
  task automatic write_capacity(input logic [8:0] v);
    in_valid_i <= 1'b0;
    while (unescaped_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i    <= 1'b1;
    cfg_capacity_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    cap = v;
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !quiet && ($urandom_range(0, 99) < 12);
    end
  end

  // Result checker
  always @(posedge clk_i) begin : result_check
    res_t got;
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{event_res_o, value_o, written_o, truncated_o, last_o};
      if (unescaped_q.size() == 0) begin
        $display("%0t: unexpected result ev=%0d val=%02h wr=%0d trunc=%0b last=%0b",
                 $time, got.ev, got.val, got.wr, got.trunc, got.last);
        fail_cnt++;
      end else begin
        want = unescaped_q.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected ev=%0d val=%02h wr=%0d trunc=%0b last=%0b",
                   $time, want.ev, want.val, want.wr, want.trunc, want.last);
          $display("%0t:          actual   ev=%0d val=%02h wr=%0d trunc=%0b last=%0b",
                   $time, got.ev, got.val, got.wr, got.trunc, got.last);
          fail_cnt++;
        end
      end
    end
  end

  // Run limit
  initial begin
    #3000000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [8:0] caps[NUM_PHASES];
    int         start;
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_capacity_i = 9'd0;
    in_valid_i     = 1'b0;
    ch_i           = 8'h00;
    out_stall_i    = 1'b0;
    fail_cnt       = 0;
    chars_sent     = 0;
    quiet          = 1'b0;
    hold_req       = 0;
    hold_seen      = 0;
    hold_left      = 0;
    ph             = PH_IDLE;
    nhex           = 2'd0;
    cp             = 16'h0000;
    cnt            = 8'd0;
    drop           = 1'b0;
    cap            = 9'd64;

    // Directed: errors while idle, whitespace, empty string, extremes, escapes, \u cases
    dir_tab = '{
      '{CH_NUL,    1'b1, EV_NOOPEN, 8'd0, 1'b0},
      '{8'hFF,     1'b1, EV_NOOPEN, 8'd0, 1'b0},
      '{CH_SPACE,  1'b0, EV_DATA,   8'd0, 1'b0},
      '{CH_TAB,    1'b0, EV_DATA,   8'd0, 1'b0},
      '{CH_LF,     1'b0, EV_DATA,   8'd0, 1'b0},
      '{CH_CR,     1'b0, EV_DATA,   8'd0, 1'b0},
      '{CH_QUOTE,  1'b0, EV_DATA,   8'd0, 1'b0},
      '{CH_QUOTE,  1'b1, EV_CLOSE,  8'd0, 1'b0},
      '{CH_QUOTE,  1'b0, EV_DATA,   8'd0, 1'b0},
      '{8'h01,     1'b0, EV_DATA,   8'd0, 1'b0},
      '{8'hFF,     1'b0, EV_DATA,   8'd0, 1'b0},
      '{CH_BSLASH, 1'b0, EV_DATA,   8'd0, 1'b0},
      '{CH_N,      1'b0, EV_DATA,   8'd0, 1'b0},
      '{CH_BSLASH, 1'b0, EV_DATA,   8'd0, 1'b0},
      '{CH_U,      1'b0, EV_DATA,   8'd0, 1'b0},
      '{"F",       1'b0, EV_DATA,   8'd0, 1'b0},
      '{"f",       1'b0, EV_DATA,   8'd0, 1'b0},
      '{"z",       1'b0, EV_DATA,   8'd0, 1'b0},
      '{"f",       1'b0, EV_DATA,   8'd0, 1'b0},
      '{CH_BSLASH, 1'b0, EV_DATA,   8'd0, 1'b0},
      '{CH_U,      1'b0, EV_DATA,   8'd0, 1'b0},
      '{"a",       1'b0, EV_DATA,   8'd0, 1'b0},
      '{CH_NUL,    1'b0, EV_DATA,   8'd0, 1'b0},
      '{CH_QUOTE,  1'b0, EV_DATA,   8'd0, 1'b0},
      '{CH_BSLASH, 1'b0, EV_DATA,   8'd0, 1'b0}
    };
    caps = '{9'd0, 9'd1, 9'd2, 9'd3, 9'd5, 9'd256, 9'd511, 9'd300, 9'd130,
             9'($urandom_range(1, 256))};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      send_char(dir_tab[i].ch, dir_tab[i].typed,
                '{dir_tab[i].ev, 8'h00, dir_tab[i].wr, dir_tab[i].trunc, 1'b1});
    end
    // end of text right after a backslash
    send_char(CH_NUL, 1'b1, '{EV_END, 8'h00, 8'd0, 1'b0, 1'b1});

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_capacity(caps[p]);
      quiet = (p == 6);
      // fill past the saturated limit once, behind a long receiver hold-off
      if (p == 6) begin
        hold_req++;
        send_char(CH_QUOTE);
        repeat (258) send_char(8'($urandom_range(8'h23, 8'h5B)));
        send_char(CH_QUOTE);
      end
      start = chars_sent;
      while (chars_sent - start < PHASE_CHARS) send_token(caps[p] < 9'd8 ? 2 : 3);
    end
    quiet = 1'b0;

    in_valid_i <= 1'b0;
    while (unescaped_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
